FILE: design/assert_macros.svh
// Assertion macros used by the timer control RTL (dtr_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DTR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// Next-cycle implication checked outside reset.
`define DTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

FILE: design/dtr_pkg.sv
// Shared types, constants and helpers of the divider timer.
package dtr_pkg;

  localparam int unsigned MAX_TICKS = 32;
  localparam int unsigned TICK_W    = 6;
  localparam int unsigned CNT_W     = $clog2(MAX_TICKS + 1);

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  localparam logic [2:0] RELOAD_DELAY = 3'd4;
  localparam logic [4:0] TAC_FILL     = 5'h1F;
  localparam logic [7:0] OPEN_BUS     = 8'hFF;

  localparam logic [3:0] SEL_BIT [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

  typedef struct packed {
    logic accept;
    logic step;
    logic load_imm;
    logic load_tick;
  } dtr_cmd_t;

  typedef struct packed {
    logic zero_ticks;
    logic last_step;
  } dtr_stat_t;

  function automatic logic edge_sig(input logic [15:0] sys, input logic [2:0] tac);
    edge_sig = tac[2] & sys[SEL_BIT[tac[1:0]]];
  endfunction

endpackage

FILE: design/dtr_datapath.sv
// Timer registers, T-state step logic, bus decode and result register.
module dtr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtr_pkg::dtr_cmd_t cmd_i,
  output dtr_pkg::dtr_stat_t stat_o,
  input  logic [1:0]        kind_i,
  input  logic [5:0]        tick_count_i,
  input  logic [15:0]       bus_address_i,
  input  logic [7:0]        write_data_i,
  output logic [7:0]        read_data_o,
  output logic              irq_request_o
);
  import dtr_pkg::*;

  logic [15:0] sys_q, sys_d;
  logic [7:0]  tima_q, tima_d;
  logic [7:0]  tma_q, tma_d;
  logic [2:0]  tac_q, tac_d;
  logic [2:0]  cd_q, cd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        acc_q, acc_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        irq_q, irq_d;

  logic [CNT_W-1:0] sat_cnt;
  logic [7:0]  rd_mux;
  logic        irq_now;
  logic [2:0]  st_cd;
  logic [7:0]  st_tima;
  logic [15:0] sys_inc;
  logic        is_wr;

  assign sat_cnt = (tick_count_i > TICK_W'(MAX_TICKS)) ? CNT_W'(MAX_TICKS)
                                                       : CNT_W'(tick_count_i);
  assign stat_o.zero_ticks = (sat_cnt == '0);
  assign stat_o.last_step  = (cnt_q == CNT_W'(1));
  assign sys_inc = sys_q + 16'd1;
  assign is_wr   = cmd_i.accept && (kind_i == KIND_WRITE);

  always_comb begin
    case (bus_address_i)
      ADDR_DIV:  rd_mux = sys_q[15:8];
      ADDR_TIMA: rd_mux = tima_q;
      ADDR_TMA:  rd_mux = tma_q;
      ADDR_TAC:  rd_mux = {TAC_FILL, tac_q};
      default:   rd_mux = OPEN_BUS;
    endcase
  end

  // one T-state: countdown, then counter advance and edge detect
  always_comb begin
    st_cd   = cd_q;
    st_tima = tima_q;
    irq_now = 1'b0;
    if (cd_q != 3'd0) begin
      st_cd = cd_q - 3'd1;
      if (st_cd == 3'd0) begin
        st_tima = tma_q;
        irq_now = 1'b1;
      end
    end
    if (edge_sig(sys_q, tac_q) && !edge_sig(sys_inc, tac_q)) begin
      st_tima = st_tima + 8'd1;
      if (st_tima == 8'd0) begin
        st_cd = RELOAD_DELAY;
      end
    end
  end

  always_comb begin
    sys_d   = sys_q;
    tima_d  = tima_q;
    tma_d   = tma_q;
    tac_d   = tac_q;
    cd_d    = cd_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rdata_d = rdata_q;
    irq_d   = irq_q;
    if (cmd_i.accept && kind_i == KIND_TICK) begin
      cnt_d = sat_cnt;
      acc_d = 1'b0;
    end
    if (cmd_i.step) begin
      sys_d  = sys_inc;
      tima_d = st_tima;
      cd_d   = st_cd;
      cnt_d  = cnt_q - CNT_W'(1);
      acc_d  = acc_q | irq_now;
    end
    if (is_wr) begin
      case (bus_address_i)
        ADDR_DIV: begin
          sys_d = '0;
          if (edge_sig(sys_q, tac_q)) begin
            tima_d = tima_q + 8'd1;
            if (tima_d == 8'd0) cd_d = RELOAD_DELAY;
          end
        end
        ADDR_TIMA: tima_d = write_data_i;
        ADDR_TMA:  tma_d  = write_data_i;
        ADDR_TAC: begin
          tac_d = write_data_i[2:0];
          if (edge_sig(sys_q, tac_q) && !edge_sig(sys_q, tac_d)) begin
            tima_d = tima_q + 8'd1;
            if (tima_d == 8'd0) cd_d = RELOAD_DELAY;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.load_imm) begin
      rdata_d = (kind_i == KIND_READ) ? rd_mux : 8'd0;
      irq_d   = 1'b0;
    end
    if (cmd_i.load_tick) begin
      rdata_d = 8'd0;
      irq_d   = acc_q | irq_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_q  <= '0;
      tima_q <= '0;
      tma_q  <= '0;
      tac_q  <= '0;
      cd_q   <= '0;
      cnt_q  <= '0;
      acc_q  <= 1'b0;
    end else begin
      sys_q  <= sys_d;
      tima_q <= tima_d;
      tma_q  <= tma_d;
      tac_q  <= tac_d;
      cd_q   <= cd_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    irq_q   <= irq_d;
  end

  assign read_data_o   = rdata_q;
  assign irq_request_o = irq_q;

endmodule

FILE: design/dtr_ctrl.sv
// Request sequencing and result handshake of the divider timer.
`include "assert_macros.svh"

module dtr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dtr_pkg::dtr_stat_t stat_i,
  output dtr_pkg::dtr_cmd_t  cmd_o
);
  import dtr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic ov_q, ov_d;
  logic is_tick;
  logic start_run;

  assign in_ready_o = (state_q == ST_IDLE) && (!ov_q || out_ready_i);
  assign is_tick    = (kind_i == KIND_TICK);

  assign cmd_o.accept    = in_valid_i && in_ready_o;
  assign cmd_o.step      = (state_q == ST_RUN);
  assign cmd_o.load_imm  = cmd_o.accept && (!is_tick || stat_i.zero_ticks);
  assign cmd_o.load_tick = cmd_o.step && stat_i.last_step;
  assign start_run       = cmd_o.accept && is_tick && !stat_i.zero_ticks;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_run) state_d = ST_RUN;
      ST_RUN:  if (stat_i.last_step) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (cmd_o.load_imm || cmd_o.load_tick) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  `DTR_ASSERT_IMPL(a_run_no_accept, state_q == ST_RUN, !in_ready_o)
  `DTR_ASSERT_IMPL(a_tick_out_free, cmd_o.load_tick, !ov_q)
  `DTR_ASSERT_NEXT(a_start_runs, start_run, state_q == ST_RUN && !ov_q)

endmodule

FILE: design/divider_timer_with_reload.sv
// Top level of the divider timer with delayed overflow reload.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: a tick run,
//   a register read or a register write, selected by kind_i.
//   Output channel (out_valid_o/out_ready_i) returns one result per request:
//   read_data_o and irq_request_o.
// Timing:
//   Reads, writes, unused kinds and zero-length tick runs finish at the
//   accepting edge; the result is valid in the next cycle.
//   A tick run of N T-states (N saturated at 32) steps the timer once per
//   clock in the single T-state step unit; the result is valid the cycle
//   after the last step.
//   A new request is taken once the block is idle and the result register
//   is empty or being drained in the same cycle.
// Reset: all timer registers clear to zero and no result is pending.
// Stall: while out_ready_i is low the result holds in the output register
//   and in_ready_o stays low until it is taken.
module divider_timer_with_reload (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [5:0]  tick_count_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        irq_request_o
);
  import dtr_pkg::*;

  dtr_cmd_t  cmd;
  dtr_stat_t stat;

  dtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dtr_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .tick_count_i  (tick_count_i),
    .bus_address_i (bus_address_i),
    .write_data_i  (write_data_i),
    .read_data_o   (read_data_o),
    .irq_request_o (irq_request_o)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the divider timer with delayed overflow reload.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtr_pkg::*;

  localparam logic [1:0]  KIND_SPARE   = 2'd3;
  localparam int unsigned RAND_ITEMS   = 1400;
  localparam int unsigned CALM_TAIL    = 200;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct {
    logic [1:0]  kind;
    logic [5:0]  ticks;
    logic [15:0] addr;
    logic [7:0]  data;
    int unsigned gap;
  } timer_req_t;

  typedef struct {
    logic [7:0] rdata;
    logic       irq;
  } timer_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [5:0]  tick_count = '0;
  logic [15:0] bus_address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic        irq_request;

  timer_req_t  request_q[$];
  timer_rsp_t  timer_exp_q[$];
  timer_req_t  cur_req;
  int unsigned total_reqs = 0;
  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned cycle_cnt = 0;

  logic [15:0] div_cnt = '0;
  logic [7:0]  tima = '0;
  logic [7:0]  tma = '0;
  logic [2:0]  tac = '0;
  logic [2:0]  reload_wait = '0;

  divider_timer_with_reload dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .tick_count_i  (tick_count),
    .bus_address_i (bus_address),
    .write_data_i  (write_data),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .read_data_o   (read_data),
    .irq_request_o (irq_request)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic timer_tap(input logic [15:0] cnt, input logic [2:0] ctl);
    logic [3:0] pos;
    pos = SEL_BIT[ctl[1:0]];
    return ctl[2] & cnt[pos];
  endfunction

  task automatic count_edge(input logic was, input logic now);
    if (was && !now) begin
      tima = tima + 8'd1;
      if (tima == 8'd0) reload_wait = RELOAD_DELAY;
    end
  endtask

  task automatic predict_request(input timer_req_t r);
    timer_rsp_t  rsp;
    int unsigned steps;
    logic        was;
    rsp.rdata = '0;
    rsp.irq   = 1'b0;
    case (r.kind)
      KIND_TICK: begin
        steps = (r.ticks > 6'(MAX_TICKS)) ? MAX_TICKS : 32'(r.ticks);
        repeat (steps) begin
          if (reload_wait != 3'd0) begin
            reload_wait = reload_wait - 3'd1;
            if (reload_wait == 3'd0) begin
              tima    = tma;
              rsp.irq = 1'b1;
            end
          end
          was     = timer_tap(div_cnt, tac);
          div_cnt = div_cnt + 16'd1;
          count_edge(was, timer_tap(div_cnt, tac));
        end
      end
      KIND_READ: begin
        case (r.addr)
          ADDR_DIV:  rsp.rdata = div_cnt[15:8];
          ADDR_TIMA: rsp.rdata = tima;
          ADDR_TMA:  rsp.rdata = tma;
          ADDR_TAC:  rsp.rdata = {TAC_FILL, tac};
          default:   rsp.rdata = OPEN_BUS;
        endcase
      end
      KIND_WRITE: begin
        case (r.addr)
          ADDR_DIV: begin
            was     = timer_tap(div_cnt, tac);
            div_cnt = '0;
            count_edge(was, timer_tap(div_cnt, tac));
          end
          ADDR_TIMA: tima = r.data;
          ADDR_TMA:  tma = r.data;
          ADDR_TAC: begin
            was = timer_tap(div_cnt, tac);
            tac = r.data[2:0];
            count_edge(was, timer_tap(div_cnt, tac));
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    timer_exp_q.push_back(rsp);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  task automatic queue_request(input logic [1:0] k, input logic [5:0] t,
                               input logic [15:0] a, input logic [7:0] d,
                               input bit quiet);
    timer_req_t r;
    r.kind  = k;
    r.ticks = t;
    r.addr  = a;
    r.data  = d;
    r.gap   = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    request_q.push_back(r);
  endtask

  initial begin
    logic [1:0]  k;
    logic [5:0]  t;
    logic [15:0] a;
    logic [7:0]  d;
    int unsigned pick;
    bit          quiet;

    queue_request(KIND_READ, '0, ADDR_DIV, '0, 0);
    queue_request(KIND_READ, '0, ADDR_TIMA, '0, 0);
    queue_request(KIND_READ, '0, ADDR_TMA, '0, 0);
    queue_request(KIND_READ, '0, ADDR_TAC, '0, 0);
    queue_request(KIND_READ, '0, 16'h0000, '0, 0);
    queue_request(KIND_READ, '0, 16'hFFFF, '0, 0);
    queue_request(KIND_SPARE, 6'h3F, ADDR_TAC, 8'hFF, 0);
    queue_request(KIND_WRITE, '0, 16'h0000, 8'hFF, 0);
    queue_request(KIND_WRITE, '0, ADDR_TMA, 8'hA5, 0);
    queue_request(KIND_WRITE, '0, ADDR_TIMA, 8'hFF, 0);
    queue_request(KIND_WRITE, '0, ADDR_TAC, 8'hFD, 0);
    queue_request(KIND_TICK, 6'd0, '0, '0, 0);
    queue_request(KIND_TICK, 6'h3F, 16'hFFFF, 8'hFF, 0);
    queue_request(KIND_READ, '0, ADDR_TIMA, '0, 0);
    queue_request(KIND_READ, '0, ADDR_TAC, '0, 0);
    queue_request(KIND_TICK, 6'd8, '0, '0, 0);
    queue_request(KIND_WRITE, '0, ADDR_TIMA, 8'hFF, 0);
    queue_request(KIND_WRITE, '0, ADDR_DIV, 8'h00, 0);
    queue_request(KIND_WRITE, '0, ADDR_TIMA, 8'h12, 0);
    queue_request(KIND_TICK, 6'd4, '0, '0, 0);
    queue_request(KIND_READ, '0, ADDR_TIMA, '0, 0);
    queue_request(KIND_TICK, 6'd12, '0, '0, 0);
    queue_request(KIND_WRITE, '0, ADDR_TAC, 8'h04, 0);
    queue_request(KIND_WRITE, '0, ADDR_TAC, 8'h00, 0);
    queue_request(KIND_TICK, 6'd33, '0, '0, 0);
    queue_request(KIND_READ, '0, ADDR_DIV, '0, 0);

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      k = (pick < 45) ? KIND_TICK : (pick < 70) ? KIND_READ :
          (pick < 95) ? KIND_WRITE : KIND_SPARE;
      t = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) :
                                        6'($urandom_range(0, 32));
      a = ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                                        ADDR_DIV + 16'($urandom_range(0, 3));
      d = 8'($urandom_range(0, 255));
      if ((a == ADDR_TIMA || a == ADDR_TMA) && $urandom_range(0, 1) == 0)
        d = 8'($urandom_range(8'hE0, 8'hFF));
      if (k == KIND_WRITE && a == ADDR_TAC && $urandom_range(0, 2) != 0)
        d[2] = 1'b1;
      quiet = (i >= RAND_ITEMS - CALM_TAIL) || (i >= 600 && i < 700);
      queue_request(k, t, a, d, quiet);
    end
    total_reqs = request_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < total_reqs || timer_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (timer_exp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", timer_exp_q.size()));
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(cur_req);
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req     = request_q.pop_front();
          kind        <= cur_req.kind;
          tick_count  <= cur_req.ticks;
          bus_address <= cur_req.addr;
          write_data  <= cur_req.data;
          in_valid    <= 1'b1;
          send_gap    = cur_req.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && recv_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    timer_rsp_t want;
    bit         calm;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_cnt <= recv_cnt + 1;
        if (timer_exp_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: data %02h irq %0b",
                                    read_data, irq_request));
        end else begin
          want = timer_exp_q.pop_front();
          if (read_data !== want.rdata)
            report_mismatch($sformatf("result %0d read_data %02h, want %02h",
                                      recv_cnt, read_data, want.rdata));
          if (irq_request !== want.irq)
            report_mismatch($sformatf("result %0d irq_request %0b, want %0b",
                                      recv_cnt, irq_request, want.irq));
        end
      end
      calm = (recv_cnt >= 600 && recv_cnt < 700) || (recv_cnt + CALM_TAIL >= total_reqs);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

FILE: filelist.f
+incdir+design
design/dtr_pkg.sv
design/dtr_datapath.sv
design/dtr_ctrl.sv
design/divider_timer_with_reload.sv
tb/tb.sv
